[rtl/core/b64d_pkg.sv]
// b64d_pkg: shared types, result codes and the character table of the base64 decoder.
// No dependencies; imported by every module under rtl/core.
`timescale 1ns / 1ps

package b64d_pkg;

    // Result kinds carried in result_kind
    localparam logic [1:0] KIND_DATA     = 2'd0;
    localparam logic [1:0] KIND_OK       = 2'd1;
    localparam logic [1:0] KIND_BAD_CHAR = 2'd2;
    localparam logic [1:0] KIND_BAD_LEN  = 2'd3;

    // Results one character can cause: three bytes and one status
    localparam int SLOTS = 4;
    localparam int STATUS_SLOT = SLOTS - 1;

    // Depth of the queue between front and back
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    // Input beat
    typedef struct packed {
        logic [7:0] symbol;
        logic       final_symbol;
    } in_item_t;

    // Result beat
    typedef struct packed {
        logic [1:0] result_kind;
        logic [7:0] data_byte;
        logic       run_last;
    } out_item_t;

    // Classified character: invalid flag, pad flag, sextet value
    typedef struct packed {
        logic       invalid;
        logic       pad;
        logic [5:0] value;
    } sextet_t;

    // One pending result inside a bundle
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
    } slot_t;

    // All results caused by one character; mask marks the slots in use
    typedef struct packed {
        logic [SLOTS-1:0]       mask;
        slot_t [SLOTS-1:0]      slots;
    } bundle_t;

    // Map a character to its sextet, the pad marker or invalid
    function automatic sextet_t sextet_of(input logic [7:0] ch);
        sextet_t s;
        s = '{invalid: 1'b0, pad: 1'b0, value: 6'd0};
        if (ch >= 8'h41 && ch <= 8'h5A) begin
            s.value = 6'(ch - 8'h41);
        end else if (ch >= 8'h61 && ch <= 8'h7A) begin
            s.value = 6'(ch - 8'h61 + 8'd26);
        end else if (ch >= 8'h30 && ch <= 8'h39) begin
            s.value = 6'(ch - 8'h30 + 8'd52);
        end else if (ch == 8'h2B) begin
            s.value = 6'd62;
        end else if (ch == 8'h2F) begin
            s.value = 6'd63;
        end else if (ch == 8'h3D) begin
            s.pad = 1'b1;
        end else begin
            s.invalid = 1'b1;
        end
        return s;
    endfunction

    // Space, tab, CR and LF are skipped
    function automatic logic is_blank(input logic [7:0] ch);
        return (ch == 8'h20) || (ch == 8'h09) || (ch == 8'h0D) || (ch == 8'h0A);
    endfunction

endpackage

[rtl/core/b64d_front.sv]
// b64d_front: accepts characters, tracks group position and error, builds result bundles.
// Depends on b64d_pkg.
`timescale 1ns / 1ps

module b64d_front
    import b64d_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  in_item_t item,
    input  logic     accept,
    output bundle_t  bundle,
    output logic     bundle_push
);

    logic [1:0] pos_reg;
    logic [1:0] pos_next;
    logic       err_reg;
    logic       err_next;
    sextet_t    held_reg [0:2];

    sextet_t    sx;
    logic       active;
    logic       hold_wr;
    bundle_t    bnd;
    sextet_t    a;
    sextet_t    b;
    sextet_t    c;
    logic [1:0] status;

    // Classify the character and form its results
    always_comb
    begin
        sx       = sextet_of(item.symbol);
        active   = !err_reg && !is_blank(item.symbol);
        pos_next = pos_reg;
        err_next = err_reg;
        hold_wr  = 1'b0;
        a        = held_reg[0];
        b        = held_reg[1];
        c        = held_reg[2];
        bnd      = '0;
        status   = KIND_OK;

        if (active && sx.invalid) begin
            err_next = 1'b1;
        end else if (active && pos_reg != 2'd3) begin
            hold_wr  = 1'b1;
            pos_next = pos_reg + 2'd1;
        end else if (active) begin
            // Group closes: one byte per pair of non-pad sextets
            bnd.mask[0]       = !a.pad && !b.pad;
            bnd.slots[0].kind = KIND_DATA;
            bnd.slots[0].data = {a.value, b.value[5:4]};
            bnd.mask[1]       = !b.pad && !c.pad;
            bnd.slots[1].kind = KIND_DATA;
            bnd.slots[1].data = {b.value[3:0], c.value[5:2]};
            bnd.mask[2]       = !c.pad && !sx.pad;
            bnd.slots[2].kind = KIND_DATA;
            bnd.slots[2].data = {c.value[1:0], sx.value};
            pos_next = 2'd0;
        end

        // Status on the final character; error outranks bad length
        if (item.final_symbol) begin
            if (err_next) begin
                status = KIND_BAD_CHAR;
            end else if (pos_next != 2'd0) begin
                status = KIND_BAD_LEN;
            end
            bnd.mask[STATUS_SLOT]       = 1'b1;
            bnd.slots[STATUS_SLOT].kind = status;
            bnd.slots[STATUS_SLOT].data = 8'd0;
            pos_next = 2'd0;
            err_next = 1'b0;
        end
    end

    assign bundle      = bnd;
    assign bundle_push = accept && (bnd.mask != '0);

    // Message state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pos_reg <= 2'd0;
            err_reg <= 1'b0;
        end else if (accept) begin
            pos_reg <= pos_next;
            err_reg <= err_next;
        end
    end

    // Held sextets of the open group
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++) begin
            if (accept && hold_wr && pos_reg == 2'(i)) begin
                held_reg[i] <= sx;
            end
        end
    end

endmodule

[rtl/core/b64d_queue.sv]
// b64d_queue: short bundle queue between front and back.
// Depends on b64d_pkg.
`timescale 1ns / 1ps

module b64d_queue
    import b64d_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    wr,
    input  bundle_t wr_data,
    input  logic    rd,
    output bundle_t rd_data,
    output logic    full,
    output logic    empty
);

    bundle_t        mem_reg [0:QDEPTH-1];
    logic [QAW-1:0] wr_ptr_reg;
    logic [QAW-1:0] rd_ptr_reg;
    logic [QAW:0]   count_reg;
    logic [QAW:0]   count_next;
    logic           do_wr;
    logic           do_rd;

    assign full    = (count_reg == (QAW+1)'(QDEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr && !full;
    assign do_rd   = rd && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    // Occupancy
    always_comb
    begin
        count_next = count_reg;
        if (do_wr && !do_rd) begin
            count_next = count_reg + (QAW+1)'(1);
        end else if (do_rd && !do_wr) begin
            count_next = count_reg - (QAW+1)'(1);
        end
    end

    // Pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_wr) begin
                wr_ptr_reg <= wr_ptr_reg + QAW'(1);
            end
            if (do_rd) begin
                rd_ptr_reg <= rd_ptr_reg + QAW'(1);
            end
            count_reg <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_wr) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

[rtl/core/b64d_back.sv]
// b64d_back: unpacks bundles into single result beats, oldest slot first.
// Depends on b64d_pkg.
`timescale 1ns / 1ps

module b64d_back
    import b64d_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  bundle_t   q_data,
    input  logic      q_empty,
    output logic      q_rd,
    input  logic      pop,
    output logic      empty,
    output out_item_t result
);

    logic [SLOTS-1:0] mask_reg;
    logic [SLOTS-1:0] mask_next;
    slot_t [SLOTS-1:0] slots_reg;
    logic [SLOTS-1:0] low_bit;
    logic [SLOTS-1:0] rest;
    slot_t            cur;
    logic             take;

    // Lowest pending slot
    always_comb
    begin
        low_bit = mask_reg & (~mask_reg + SLOTS'(1));
        rest    = mask_reg & ~low_bit;
        cur     = slots_reg[0];
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (low_bit[i]) begin
                cur = slots_reg[i];
            end
        end
    end

    assign empty              = (mask_reg == '0);
    assign result.result_kind = cur.kind;
    assign result.data_byte   = cur.data;
    assign result.run_last    = (rest == '0);

    // Refill from the queue when the bundle is spent or its last beat leaves
    assign take = empty || (pop && rest == '0);
    assign q_rd = take && !q_empty;

    always_comb
    begin
        mask_next = mask_reg;
        if (take) begin
            mask_next = q_empty ? '0 : q_data.mask;
        end else if (pop) begin
            mask_next = rest;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mask_reg <= '0;
        end else begin
            mask_reg <= mask_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_rd) begin
            slots_reg <= q_data.slots;
        end
    end

endmodule

[rtl/core/base64_stream_decoder_core.sv]
// base64_stream_decoder_core: top level of the streaming base64 decoder.
// Depends on b64d_pkg, b64d_front, b64d_queue, b64d_back.
//
//   channel   handshake        payload     accepted when
//   input     push / full      item        push && !full
//   result    empty / pop      result      pop && !empty
//
// One character per cycle unless full; the front classifies each as it is taken.
// A closed group or a final character queues one bundle (up to four results);
// the back sends one result beat per cycle while the consumer pops.
// full rises only when the four-entry bundle queue fills behind a stalled consumer.
// Reset clears group position, error flag, queue pointers and the pending mask.
`timescale 1ns / 1ps

module base64_stream_decoder_core
    import b64d_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    output logic      full,
    input  in_item_t  item,
    output logic      empty,
    input  logic      pop,
    output out_item_t result
);

    bundle_t f_bundle;
    logic    f_push;
    bundle_t q_data;
    logic    q_rd;
    logic    q_empty;
    logic    accept;

    assign accept = push && !full;

    // Front: classify and group
    b64d_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (item),
        .accept      (accept),
        .bundle      (f_bundle),
        .bundle_push (f_push)
    );

    // Queue between front and back
    b64d_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (f_push),
        .wr_data (f_bundle),
        .rd      (q_rd),
        .rd_data (q_data),
        .full    (full),
        .empty   (q_empty)
    );

    // Back: serialize results
    b64d_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_data  (q_data),
        .q_empty (q_empty),
        .q_rd    (q_rd),
        .pop     (pop),
        .empty   (empty),
        .result  (result)
    );

endmodule
